[design/i2cw_pkg.sv]
// shared types, constants and register codes for the i2c master write engine
`timescale 1ns / 1ps
`default_nettype none
package i2cw_pkg;

  // field and counter widths
  localparam int OPCODE_W  = 2;
  localparam int BYTE_BITS = 8;
  localparam int BIT_CNT_W = 4;
  localparam int TICK_W    = 16;
  localparam int CFG_IDX_W = 3;

  // default depth of the command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // register reset values
  localparam logic [TICK_W-1:0] LOW_TICKS_RST        = 16'd26;
  localparam logic [TICK_W-1:0] SETUP_TICKS_RST      = 16'd2;
  localparam logic [TICK_W-1:0] HIGH_TICKS_RST       = 16'd12;
  localparam logic [TICK_W-1:0] START_HOLD_TICKS_RST = 16'd12;
  localparam logic [TICK_W-1:0] STOP_SETUP_TICKS_RST = 16'd12;
  localparam logic [TICK_W-1:0] IDLE_TICKS_RST       = 16'd26;

  // opcodes as seen on the input channel
  localparam logic [OPCODE_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_START = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_STOP  = 2'd3;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_LOW_TICKS        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SETUP_TICKS      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_TICKS       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_HOLD_TICKS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_SETUP_TICKS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TICKS       = 3'd5;

  // classified command carried through the queue
  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_START,
    CMD_WRITE,
    CMD_STOP
  } cmd_t;

  typedef struct packed {
    cmd_t                 cmd;
    logic [BYTE_BITS-1:0] data_byte;
    logic                 sda_level;
  } q_entry_t;

  // bus sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_START_HOLD = 4'd1,
    PH_BIT_LOW    = 4'd2,
    PH_BIT_SETUP  = 4'd3,
    PH_BIT_HIGH   = 4'd4,
    PH_ACK_LOW    = 4'd5,
    PH_ACK_HIGH   = 4'd6,
    PH_STOP_SETUP = 4'd7,
    PH_STOP_IDLE  = 4'd8
  } phase_t;

endpackage
`default_nettype wire

[design/i2cw_if.sv]
// valid/ready channel interfaces for command ticks and bus results
`timescale 1ns / 1ps
`default_nettype none
interface i2cw_in_if;
  logic                          valid;
  logic                          ready;
  logic [i2cw_pkg::OPCODE_W-1:0]  opcode;
  logic [i2cw_pkg::BYTE_BITS-1:0] data_byte;
  logic                          sda_level;

  modport source (output valid, opcode, data_byte, sda_level, input ready);
  modport sink   (input valid, opcode, data_byte, sda_level, output ready);
endinterface

interface i2cw_out_if;
  logic valid;
  logic ready;
  logic scl_pull_low;
  logic sda_pull_low;
  logic busy_res;
  logic ack_valid;
  logic ack_seen;

  modport source (output valid, scl_pull_low, sda_pull_low, busy_res, ack_valid, ack_seen,
                  input ready);
  modport sink   (input valid, scl_pull_low, sda_pull_low, busy_res, ack_valid, ack_seen,
                  output ready);
endinterface
`default_nettype wire

[design/i2c_master_write_engine_unit.sv]
// top level of the write-only i2c master: command front end, queue and bus sequencer
//
//  channel | dir | handshake          | beat contents
//  cmd     | in  | valid / ready      | opcode, data_byte, sda_level (one bus tick)
//  res     | out | valid / ready      | scl_pull_low, sda_pull_low, busy_res, ack_valid, ack_seen
//  cfg     | in  | cfg_we, no stall   | cfg_index, cfg_data (timing registers 0 to 5)
//
// one tick beat per cycle sustained while the result side does not stall; each beat gives exactly one result beat
// an accepted tick reaches its result through the command queue and then the
// result register
// the queue holds QUEUE_DEPTH beats, so input keeps flowing while a result waits
// reset is synchronous and returns the sequencer to idle with default timings
// a stalled result side backs up the queue and then drops cmd.ready
`timescale 1ns / 1ps
`default_nettype none
module i2c_master_write_engine_unit #(
  parameter int QUEUE_DEPTH = i2cw_pkg::QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  i2cw_in_if.sink   cmd,
  i2cw_out_if.source res,
  input  wire logic cfg_we,
  input  wire logic [i2cw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [i2cw_pkg::TICK_W-1:0] cfg_data
);
  import i2cw_pkg::*;

  q_entry_t q_entry;
  logic     q_valid;
  logic     q_pop;

  // accept and classify ticks
  i2cw_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .q_entry (q_entry),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  // run the bus sequence
  i2cw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_entry   (q_entry),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .res       (res)
  );

endmodule
`default_nettype wire

[design/i2cw_front.sv]
// front end: accepts tick beats, classifies the opcode and queues the command
`timescale 1ns / 1ps
`default_nettype none
module i2cw_front #(
  parameter int QUEUE_DEPTH = i2cw_pkg::QUEUE_DEPTH
) (
  input  wire                logic clk,
  input  wire                logic rst,
  i2cw_in_if.sink            cmd,
  output i2cw_pkg::q_entry_t q_entry,
  output logic               q_valid,
  input  wire                logic q_pop
);
  import i2cw_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  q_entry_t         slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  q_entry_t         classified;
  logic             push;
  logic             pop;

  // opcode classification
  always_comb begin
    case (cmd.opcode)
      OP_START: classified.cmd = CMD_START;
      OP_WRITE: classified.cmd = CMD_WRITE;
      OP_STOP:  classified.cmd = CMD_STOP;
      default:  classified.cmd = CMD_NONE;
    endcase
    classified.data_byte = cmd.data_byte;
    classified.sda_level = cmd.sda_level;
  end

  assign cmd.ready = (count != FULL_CNT);
  assign push      = cmd.valid && cmd.ready;
  assign q_valid   = (count != '0);
  assign pop       = q_pop && q_valid;
  assign q_entry   = slots[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= classified;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

[design/i2cw_back.sv]
// back end: timing registers, bus sequencer and result register
`timescale 1ns / 1ps
`default_nettype none
module i2cw_back (
  input  wire                logic clk,
  input  wire                logic rst,
  input  wire                logic cfg_we,
  input  wire                logic [i2cw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire                logic [i2cw_pkg::TICK_W-1:0] cfg_data,
  input  wire                i2cw_pkg::q_entry_t q_entry,
  input  wire                logic q_valid,
  output logic               q_pop,
  i2cw_out_if.source         res
);
  import i2cw_pkg::*;

  logic [TICK_W-1:0] low_ticks;
  logic [TICK_W-1:0] setup_ticks;
  logic [TICK_W-1:0] high_ticks;
  logic [TICK_W-1:0] start_hold_ticks;
  logic [TICK_W-1:0] stop_setup_ticks;
  logic [TICK_W-1:0] idle_ticks;

  phase_t               phase, phase_next;
  logic [BIT_CNT_W-1:0] bit_count, bit_count_next;
  logic [BIT_CNT_W-1:0] bit_count_inc;
  logic [BYTE_BITS-1:0] shift_byte, shift_byte_next;
  logic [TICK_W-1:0]    wait_count, wait_count_next;
  logic                 scl_drive, scl_drive_next;
  logic                 sda_drive, sda_drive_next;
  logic                 ack_flag, ack_flag_next;
  logic                 sampled;
  logic                 step;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      low_ticks        <= LOW_TICKS_RST;
      setup_ticks      <= SETUP_TICKS_RST;
      high_ticks       <= HIGH_TICKS_RST;
      start_hold_ticks <= START_HOLD_TICKS_RST;
      stop_setup_ticks <= STOP_SETUP_TICKS_RST;
      idle_ticks       <= IDLE_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOW_TICKS:        low_ticks        <= cfg_data;
        REG_SETUP_TICKS:      setup_ticks      <= cfg_data;
        REG_HIGH_TICKS:       high_ticks       <= cfg_data;
        REG_START_HOLD_TICKS: start_hold_ticks <= cfg_data;
        REG_STOP_SETUP_TICKS: stop_setup_ticks <= cfg_data;
        REG_IDLE_TICKS:       idle_ticks       <= cfg_data;
        default: ;
      endcase
    end
  end

  // one queued tick is taken whenever the result register is free or drains
  assign step          = q_valid && (!res.valid || res.ready);
  assign q_pop         = step;
  assign bit_count_inc = bit_count + BIT_CNT_W'(1);

  // sequencer next state
  always_comb begin
    phase_next      = phase;
    bit_count_next  = bit_count;
    shift_byte_next = shift_byte;
    wait_count_next = wait_count;
    scl_drive_next  = scl_drive;
    sda_drive_next  = sda_drive;
    ack_flag_next   = ack_flag;
    sampled         = 1'b0;
    if (phase == PH_IDLE) begin
      case (q_entry.cmd)
        CMD_START: begin
          scl_drive_next  = 1'b0;
          sda_drive_next  = 1'b1;
          phase_next      = PH_START_HOLD;
          wait_count_next = start_hold_ticks;
        end
        CMD_WRITE: begin
          scl_drive_next  = 1'b1;
          shift_byte_next = q_entry.data_byte;
          bit_count_next  = '0;
          phase_next      = PH_BIT_LOW;
          wait_count_next = low_ticks;
        end
        CMD_STOP: begin
          sda_drive_next  = 1'b1;
          scl_drive_next  = 1'b0;
          phase_next      = PH_STOP_SETUP;
          wait_count_next = stop_setup_ticks;
        end
        default: ;
      endcase
    end else if (wait_count != '0) begin
      wait_count_next = wait_count - TICK_W'(1);
    end else begin
      case (phase)
        PH_START_HOLD: begin
          scl_drive_next = 1'b1;
          phase_next     = PH_IDLE;
        end
        PH_BIT_LOW: begin
          sda_drive_next  = !shift_byte[BYTE_BITS-1];
          phase_next      = PH_BIT_SETUP;
          wait_count_next = setup_ticks;
        end
        PH_BIT_SETUP: begin
          scl_drive_next  = 1'b0;
          shift_byte_next = {shift_byte[BYTE_BITS-2:0], 1'b0};
          phase_next      = PH_BIT_HIGH;
          wait_count_next = high_ticks;
        end
        PH_BIT_HIGH: begin
          bit_count_next  = bit_count_inc;
          scl_drive_next  = 1'b1;
          wait_count_next = low_ticks;
          if (bit_count_inc >= BIT_CNT_W'(BYTE_BITS)) begin
            phase_next = PH_ACK_LOW;
          end else begin
            phase_next = PH_BIT_LOW;
          end
        end
        PH_ACK_LOW: begin
          sda_drive_next  = 1'b0;
          scl_drive_next  = 1'b0;
          phase_next      = PH_ACK_HIGH;
          wait_count_next = high_ticks;
        end
        PH_ACK_HIGH: begin
          ack_flag_next  = !q_entry.sda_level;
          sampled        = 1'b1;
          scl_drive_next = 1'b1;
          phase_next     = PH_IDLE;
        end
        PH_STOP_SETUP: begin
          sda_drive_next  = 1'b0;
          phase_next      = PH_STOP_IDLE;
          wait_count_next = idle_ticks;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      bit_count  <= '0;
      shift_byte <= '0;
      wait_count <= '0;
      scl_drive  <= 1'b0;
      sda_drive  <= 1'b0;
      ack_flag   <= 1'b0;
    end else if (step) begin
      phase      <= phase_next;
      bit_count  <= bit_count_next;
      shift_byte <= shift_byte_next;
      wait_count <= wait_count_next;
      scl_drive  <= scl_drive_next;
      sda_drive  <= sda_drive_next;
      ack_flag   <= ack_flag_next;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (step) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (step) begin
      res.scl_pull_low <= scl_drive_next;
      res.sda_pull_low <= sda_drive_next;
      res.busy_res     <= (phase_next != PH_IDLE);
      res.ack_valid    <= sampled;
      res.ack_seen     <= ack_flag_next;
    end
  end

endmodule
`default_nettype wire

[design/i2cw_checker.sv]
// port-level checks on the write engine, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module i2cw_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic cmd_ready,
  input wire logic res_valid,
  input wire logic res_ready,
  input wire logic res_scl_pull_low,
  input wire logic res_sda_pull_low,
  input wire logic res_busy_res,
  input wire logic res_ack_valid,
  input wire logic res_ack_seen
);

  // a stalled result beat holds its payload
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_scl_pull_low)
      && $stable(res_sda_pull_low) && $stable(res_busy_res)
      && $stable(res_ack_valid) && $stable(res_ack_seen))
    else $error("result beat changed while stalled");

  // the acknowledge beat ends the sequence with scl pulled low
  a_ack_end: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ack_valid |-> !res_busy_res && res_scl_pull_low)
    else $error("ack beat not at end of byte");

  // sda is released while the acknowledge is sampled
  a_ack_sda: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ack_valid |-> !res_sda_pull_low)
    else $error("sda driven during ack");

  // input is ready and no result is pending right after reset
  a_rst_ready: assert property (@(posedge clk)
    rst |=> cmd_ready && !res_valid)
    else $error("not ready after reset");

endmodule

bind i2c_master_write_engine_unit i2cw_checker u_checker (
  .clk              (clk),
  .rst              (rst),
  .cmd_ready        (cmd.ready),
  .res_valid        (res.valid),
  .res_ready        (res.ready),
  .res_scl_pull_low (res.scl_pull_low),
  .res_sda_pull_low (res.sda_pull_low),
  .res_busy_res     (res.busy_res),
  .res_ack_valid    (res.ack_valid),
  .res_ack_seen     (res.ack_seen)
);
`default_nettype wire

[tb/tb_top.sv]
// self-checking testbench for the write-only i2c master engine with a tick-level bus predictor
`timescale 1ns / 1ps

import i2cw_pkg::*;

// one result beat as the block presents it
typedef struct packed {
  logic scl_pull_low;
  logic sda_pull_low;
  logic busy_res;
  logic ack_valid;
  logic ack_seen;
} bus_levels_t;

class i2c_line_scoreboard;
  // timing registers as last written
  logic [TICK_W-1:0] low_ticks;
  logic [TICK_W-1:0] setup_ticks;
  logic [TICK_W-1:0] high_ticks;
  logic [TICK_W-1:0] start_hold_ticks;
  logic [TICK_W-1:0] stop_setup_ticks;
  logic [TICK_W-1:0] idle_ticks;
  // mirrored sequencer state
  phase_t               ph;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic [BYTE_BITS-1:0] shift_q;
  logic [TICK_W-1:0]    wait_q;
  logic                 scl_q;
  logic                 sda_q;
  logic                 ack_q;
  // line levels still owed by the block, oldest first
  bus_levels_t          pending_levels[$];
  int                   failures;

  function new();
    low_ticks        = LOW_TICKS_RST;
    setup_ticks      = SETUP_TICKS_RST;
    high_ticks       = HIGH_TICKS_RST;
    start_hold_ticks = START_HOLD_TICKS_RST;
    stop_setup_ticks = STOP_SETUP_TICKS_RST;
    idle_ticks       = IDLE_TICKS_RST;
    ph       = PH_IDLE;
    bit_cnt  = '0;
    shift_q  = '0;
    wait_q   = '0;
    scl_q    = 1'b0;
    sda_q    = 1'b0;
    ack_q    = 1'b0;
    failures = 0;
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [TICK_W-1:0] val);
    case (idx)
      REG_LOW_TICKS:        low_ticks = val;
      REG_SETUP_TICKS:      setup_ticks = val;
      REG_HIGH_TICKS:       high_ticks = val;
      REG_START_HOLD_TICKS: start_hold_ticks = val;
      REG_STOP_SETUP_TICKS: stop_setup_ticks = val;
      REG_IDLE_TICKS:       idle_ticks = val;
      default: ;
    endcase
  endfunction

  function bit busy();
    return ph != PH_IDLE;
  endfunction

  // the next tick closes the running sequence
  function bit ends_next();
    return wait_q == '0 &&
           (ph == PH_START_HOLD || ph == PH_ACK_HIGH || ph == PH_STOP_IDLE);
  endfunction

  function int pending();
    return pending_levels.size();
  endfunction

  // advance the sequencer by one accepted tick and queue the line levels it gives
  function void note_tick(logic [OPCODE_W-1:0] op, logic [BYTE_BITS-1:0] data,
                          logic sda_in);
    bus_levels_t lv;
    bit          sampled;
    sampled = 1'b0;
    if (ph == PH_IDLE) begin
      if (op == OP_START) begin
        scl_q  = 1'b0;
        sda_q  = 1'b1;
        ph     = PH_START_HOLD;
        wait_q = start_hold_ticks;
      end else if (op == OP_WRITE) begin
        scl_q   = 1'b1;
        shift_q = data;
        bit_cnt = '0;
        ph      = PH_BIT_LOW;
        wait_q  = low_ticks;
      end else if (op == OP_STOP) begin
        sda_q  = 1'b1;
        scl_q  = 1'b0;
        ph     = PH_STOP_SETUP;
        wait_q = stop_setup_ticks;
      end
    end else if (wait_q != '0) begin
      wait_q = wait_q - 1'b1;
    end else begin
      case (ph)
        PH_START_HOLD: begin
          scl_q = 1'b1;
          ph    = PH_IDLE;
        end
        PH_BIT_LOW: begin
          sda_q  = ~shift_q[BYTE_BITS-1];
          ph     = PH_BIT_SETUP;
          wait_q = setup_ticks;
        end
        PH_BIT_SETUP: begin
          scl_q   = 1'b0;
          shift_q = shift_q << 1;
          ph      = PH_BIT_HIGH;
          wait_q  = high_ticks;
        end
        PH_BIT_HIGH: begin
          bit_cnt = bit_cnt + 1'b1;
          scl_q   = 1'b1;
          ph      = (bit_cnt >= BYTE_BITS) ? PH_ACK_LOW : PH_BIT_LOW;
          wait_q  = low_ticks;
        end
        PH_ACK_LOW: begin
          sda_q  = 1'b0;
          scl_q  = 1'b0;
          ph     = PH_ACK_HIGH;
          wait_q = high_ticks;
        end
        PH_ACK_HIGH: begin
          ack_q   = ~sda_in;
          sampled = 1'b1;
          scl_q   = 1'b1;
          ph      = PH_IDLE;
        end
        PH_STOP_SETUP: begin
          sda_q  = 1'b0;
          ph     = PH_STOP_IDLE;
          wait_q = idle_ticks;
        end
        default: ph = PH_IDLE;
      endcase
    end
    lv = {scl_q, sda_q, ph != PH_IDLE, sampled, ack_q};
    pending_levels.push_back(lv);
  endfunction

  // compare one result beat with the oldest owed levels
  function void check_levels(bus_levels_t got);
    bus_levels_t want;
    if (pending_levels.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("result beat with nothing pending: scl %b sda %b busy %b ackv %b ack %b",
                 got.scl_pull_low, got.sda_pull_low, got.busy_res, got.ack_valid,
                 got.ack_seen);
      return;
    end
    want = pending_levels.pop_front();
    if (want !== got) begin
      failures++;
      if (failures <= 10)
        $display("mismatch at %0t: expected scl %b sda %b busy %b ackv %b ack %b, %s%b %b %b %b %b",
                 $realtime, want.scl_pull_low, want.sda_pull_low, want.busy_res,
                 want.ack_valid, want.ack_seen, "got ",
                 got.scl_pull_low, got.sda_pull_low, got.busy_res, got.ack_valid,
                 got.ack_seen);
    end
  endfunction
endclass

module tb_top;

  localparam int STALL_LIMIT = 4000;
  localparam int SDA_LOW     = 0;
  localparam int SDA_HIGH    = 1;
  localparam int SDA_RANDOM  = 2;

  typedef enum int {
    IDLE_NONE,
    IDLE_SOURCE,
    IDLE_SINK,
    IDLE_BOTH
  } idle_mode_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TICK_W-1:0]    cfg_data;

  int src_idle_pct;
  int stall_pct;
  int sent_items;
  int quiet_cycles;

  i2c_line_scoreboard sb = new();

  i2cw_in_if  cmd_if ();
  i2cw_out_if res_if ();

  i2c_master_write_engine_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_if),
    .res       (res_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // result side: check accepted beats, stall at random
  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready)
      sb.check_levels({res_if.scl_pull_low, res_if.sda_pull_low, res_if.busy_res,
                       res_if.ack_valid, res_if.ack_seen});
    res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // watchdog on cycles with no beat on either channel
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("i2c_master_write_engine_unit test failed");
    $finish;
  end

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE:   begin src_idle_pct = 0;  stall_pct = 0;  end
      IDLE_SOURCE: begin src_idle_pct = 64; stall_pct = 0;  end
      IDLE_SINK:   begin src_idle_pct = 0;  stall_pct = 64; end
      default:     begin src_idle_pct = 8;  stall_pct = 8;  end
    endcase
  endtask

  // one tick beat, with random gaps before it
  task automatic send_tick(input logic [OPCODE_W-1:0] op, input logic [BYTE_BITS-1:0] data,
                           input logic sda);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid     <= 1'b1;
    cmd_if.opcode    <= op;
    cmd_if.data_byte <= data;
    cmd_if.sda_level <= sda;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    sb.note_tick(op, data, sda);
    sent_items++;
  endtask

  // keep ticking until the sequence finishes; end_op goes on the closing tick
  task automatic fill_busy(input int noise_pct, input int sda_mode,
                           input logic [OPCODE_W-1:0] end_op);
    logic [OPCODE_W-1:0] op;
    logic                sda;
    while (sb.busy()) begin
      if (sb.ends_next() && end_op != OP_TICK)
        op = end_op;
      else if ($urandom_range(0, 99) < noise_pct)
        op = OPCODE_W'($urandom_range(0, 3));
      else
        op = OP_TICK;
      sda = (sda_mode == SDA_RANDOM) ? 1'($urandom_range(0, 1)) : (sda_mode == SDA_HIGH);
      send_tick(op, BYTE_BITS'($urandom_range(0, 255)), sda);
    end
  endtask

  // bring the block to rest before touching registers
  task automatic settle();
    fill_busy(0, SDA_RANDOM, OP_TICK);
    cmd_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic apply_timings(input logic [TICK_W-1:0] lo, input logic [TICK_W-1:0] su,
                               input logic [TICK_W-1:0] hi, input logic [TICK_W-1:0] sh,
                               input logic [TICK_W-1:0] ss, input logic [TICK_W-1:0] it);
    write_reg(REG_LOW_TICKS, lo);
    write_reg(REG_SETUP_TICKS, su);
    write_reg(REG_HIGH_TICKS, hi);
    write_reg(REG_START_HOLD_TICKS, sh);
    write_reg(REG_STOP_SETUP_TICKS, ss);
    write_reg(REG_IDLE_TICKS, it);
    cfg_we <= 1'b0;
  endtask

  // short timings keep the random part dense in bus events
  function automatic logic [TICK_W-1:0] pick_ticks();
    if ($urandom_range(0, 3) == 0)
      return '0;
    return TICK_W'($urandom_range(1, 4));
  endfunction

  // mostly start / bytes / stop transfers, some broken ones and stray commands
  task automatic random_phase(input int target);
    int first;
    int nbytes;
    first = sent_items;
    while (sent_items - first < target) begin
      if ($urandom_range(0, 99) < 80) begin
        send_tick(OP_START, BYTE_BITS'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        fill_busy(10, SDA_RANDOM, OP_TICK);
        nbytes = $urandom_range(1, 3);
        repeat (nbytes) begin
          send_tick(OP_WRITE, BYTE_BITS'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
          fill_busy(10, SDA_RANDOM, OP_TICK);
        end
        if ($urandom_range(0, 99) < 90) begin
          send_tick(OP_STOP, BYTE_BITS'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
          fill_busy(10, SDA_RANDOM, OP_TICK);
        end
      end else begin
        send_tick(OPCODE_W'($urandom_range(0, 3)), BYTE_BITS'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
        fill_busy(30, SDA_RANDOM, OPCODE_W'($urandom_range(0, 3)));
      end
      repeat ($urandom_range(0, 3))
        send_tick(OP_TICK, BYTE_BITS'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    rst              <= 1'b1;
    cmd_if.valid     <= 1'b0;
    cmd_if.opcode    <= OP_TICK;
    cmd_if.data_byte <= '0;
    cmd_if.sda_level <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_index        <= REG_LOW_TICKS;
    cfg_data         <= '0;
    sent_items = 0;
    set_idling(IDLE_NONE);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset timings: plain transfer with the slave acknowledging
    send_tick(OP_TICK, 8'h00, 1'b1);
    send_tick(OP_START, 8'h00, 1'b1);
    fill_busy(0, SDA_HIGH, OP_TICK);
    send_tick(OP_WRITE, 8'hA5, 1'b0);
    fill_busy(0, SDA_LOW, OP_TICK);
    send_tick(OP_STOP, 8'h00, 1'b1);
    fill_busy(0, SDA_HIGH, OP_TICK);
    settle();

    // zero timings: byte extremes, ack and nack, commands while busy and on the last tick
    apply_timings('0, '0, '0, '0, '0, '0);
    send_tick(OP_START, 8'h00, 1'b1);
    fill_busy(0, SDA_HIGH, OP_TICK);
    send_tick(OP_WRITE, 8'h00, 1'b1);
    fill_busy(0, SDA_LOW, OP_TICK);
    send_tick(OP_WRITE, 8'hFF, 1'b0);
    fill_busy(0, SDA_HIGH, OP_START);
    send_tick(OP_STOP, 8'hFF, 1'b1);
    fill_busy(100, SDA_RANDOM, OP_WRITE);
    send_tick(OP_WRITE, 8'h5A, 1'b0);
    fill_busy(0, SDA_LOW, OP_STOP);
    send_tick(OP_START, 8'hFF, 1'b0);
    fill_busy(0, SDA_LOW, OP_STOP);
    send_tick(OP_TICK, 8'hFF, 1'b0);
    send_tick(OP_TICK, 8'h00, 1'b1);
    settle();

    // long waits, kept to start and stop so the run stays short
    apply_timings(16'd32, 16'd32, 16'd32, 16'd32, 16'd32, 16'd32);
    send_tick(OP_START, 8'h00, 1'b1);
    fill_busy(0, SDA_RANDOM, OP_TICK);
    send_tick(OP_STOP, 8'h00, 1'b1);
    fill_busy(0, SDA_RANDOM, OP_WRITE);
    settle();

    // random traffic over several timing sets and idling patterns
    for (int i = 0; i < 8; i++) begin
      apply_timings(pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks(),
                    pick_ticks());
      set_idling(idle_mode_t'(i % 4));
      random_phase(40);
      settle();
    end

    // drain and report
    cmd_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0)
      $display("i2c_master_write_engine_unit test passed");
    else
      $display("i2c_master_write_engine_unit test failed");
    $finish;
  end

endmodule

[files.f]
design/i2cw_pkg.sv
design/i2cw_if.sv
design/i2cw_front.sv
design/i2cw_back.sv
design/i2c_master_write_engine_unit.sv
design/i2cw_checker.sv
tb/tb_top.sv
